@@ rtl/smld_pkg.sv @@
`default_nettype none
package smld_pkg;

   localparam int DEF_POINT_SLOTS = 256;
   localparam int DEF_COORD_BITS  = 24;

   localparam int INDEX_W     = 8;
   localparam int FIELD_W     = 24;
   localparam int LENGTH_W    = 25;
   localparam int UNIT_W      = 16;
   localparam int UNIT_FRAC   = 14;
   localparam int QUOTIENT_W  = UNIT_FRAC + 1;
   localparam int UNIT_ONE    = 1 << UNIT_FRAC;

   typedef enum logic {
      MODE_WRITE   = 1'b0,
      MODE_SEGMENT = 1'b1
   } mode_type;

   // wrap an index into the table: eight conditional subtract steps
   function automatic logic [16:0] slot_of(input logic [INDEX_W-1:0] idx, input int slots);
      logic [31:0] v;
      logic [31:0] s;
      v = {{(32-INDEX_W){1'b0}}, idx};
      s = 32'(slots);
      for (int k = INDEX_W - 1; k >= 0; k--) begin
         if (v >= (s << k)) begin
            v = v - (s << k);
         end
      end
      return v[16:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/smld_point_mem.sv @@
`default_nettype none
module smld_point_mem #(
   parameter int SLOTS = smld_pkg::DEF_POINT_SLOTS,
   parameter int AW    = $clog2(smld_pkg::DEF_POINT_SLOTS),
   parameter int EW    = 3 * smld_pkg::DEF_COORD_BITS
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [EW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [EW-1:0] rd_data_a,
   output logic      [EW-1:0] rd_data_b
);

   logic [EW-1:0] mem_a [SLOTS];
   logic [EW-1:0] mem_b [SLOTS];
   logic [EW-1:0] rd_a_ff;
   logic [EW-1:0] rd_b_ff;

   // two copies give one read port per endpoint
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_data;
         mem_b[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr_a];
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

@@ rtl/smld_sqrt.sv @@
`default_nettype none
module smld_sqrt #(
   parameter int RW = smld_pkg::DEF_COORD_BITS + 1,
   parameter int SW = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [2*RW-1:0] in_value,
   input  wire logic [SW-1:0]   in_side,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic      [RW-1:0]   out_root,
   output logic      [SW-1:0]   out_side
);

   localparam int NW  = 2 * RW;
   localparam int RMW = RW + 2;

   logic            v_ff    [RW+1];
   logic [NW-1:0]   n_ff    [RW+1];
   logic [RW-1:0]   rem_ff  [RW+1];
   logic [RW-1:0]   root_ff [RW+1];
   logic [SW-1:0]   side_ff [RW+1];
   logic            ready   [RW+2];
   logic [RW-1:0]   rem_in  [RW];
   logic [RW-1:0]   root_in [RW];

   assign ready[RW+1] = out_ready;

   for (genvar j = 0; j <= RW; j++) begin : g_ready
      assign ready[j] = !v_ff[j] || ready[j+1];
   end

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      assign rem_sh = {rem_ff[k], n_ff[k][NW-1-2*k -: 2]};
      assign trial  = {root_ff[k], 2'b01};
      always_comb begin
         if (rem_sh >= trial) begin
            rem_in[k]  = RW'(rem_sh - trial);
            root_in[k] = {root_ff[k][RW-2:0], 1'b1};
         end else begin
            rem_in[k]  = RW'(rem_sh);
            root_in[k] = {root_ff[k][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ready[k+1]) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k+1]) begin
            n_ff[k+1]    <= n_ff[k];
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         n_ff[0]    <= in_value;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = v_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];

endmodule
`default_nettype wire

@@ rtl/smld_div.sv @@
`default_nettype none
module smld_div #(
   parameter int MW = smld_pkg::DEF_COORD_BITS,
   parameter int LW = smld_pkg::DEF_COORD_BITS + 1,
   parameter int SW = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [MW-1:0]                     in_mag_x,
   input  wire logic [MW-1:0]                     in_mag_y,
   input  wire logic [LW-1:0]                     in_len,
   input  wire logic [SW-1:0]                     in_side,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic      [smld_pkg::QUOTIENT_W-1:0]   out_quot_x,
   output logic      [smld_pkg::QUOTIENT_W-1:0]   out_quot_y,
   output logic      [LW-1:0]                     out_len,
   output logic      [SW-1:0]                     out_side
);

   localparam int QB = smld_pkg::QUOTIENT_W;
   localparam int DW = MW + smld_pkg::UNIT_FRAC;
   localparam int CW = LW + QB - 1;

   logic            v_ff    [QB+1];
   logic [DW-1:0]   rem_ff  [QB+1][2];
   logic [QB-1:0]   quot_ff [QB+1][2];
   logic [LW-1:0]   len_ff  [QB+1];
   logic [SW-1:0]   side_ff [QB+1];
   logic            ready   [QB+2];
   logic [DW-1:0]   rem_in  [QB][2];
   logic [QB-1:0]   quot_in [QB][2];

   assign ready[QB+1] = out_ready;

   for (genvar j = 0; j <= QB; j++) begin : g_ready
      assign ready[j] = !v_ff[j] || ready[j+1];
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [CW-1:0] dsh;
      assign dsh = CW'(len_ff[k]) << (QB - 1 - k);

      for (genvar l = 0; l < 2; l++) begin : g_lane
         always_comb begin
            if (CW'(rem_ff[k][l]) >= dsh) begin
               rem_in[k][l]  = DW'(CW'(rem_ff[k][l]) - dsh);
               quot_in[k][l] = {quot_ff[k][l][QB-2:0], 1'b1};
            end else begin
               rem_in[k][l]  = rem_ff[k][l];
               quot_in[k][l] = {quot_ff[k][l][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ready[k+1]) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k+1]) begin
            rem_ff[k+1]  <= rem_in[k];
            quot_ff[k+1] <= quot_in[k];
            len_ff[k+1]  <= len_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         rem_ff[0][0]  <= {in_mag_x, {smld_pkg::UNIT_FRAC{1'b0}}};
         rem_ff[0][1]  <= {in_mag_y, {smld_pkg::UNIT_FRAC{1'b0}}};
         quot_ff[0][0] <= '0;
         quot_ff[0][1] <= '0;
         len_ff[0]     <= in_len;
         side_ff[0]    <= in_side;
      end
   end

   assign in_ready   = ready[0];
   assign out_valid  = v_ff[QB];
   assign out_quot_x = quot_ff[QB][0];
   assign out_quot_y = quot_ff[QB][1];
   assign out_len    = len_ff[QB];
   assign out_side   = side_ff[QB];

endmodule
`default_nettype wire

@@ rtl/segment_midpoint_length_direction_unit.sv @@
// Segment midpoint, planar length and direction unit.
// Request channel (req_*): mode 0 stores x, y, z at slot first_index and
// produces no response; mode 1 reads slots first_index (start) and
// second_index (end) and produces one response transfer.
// Response channel (rsp_*): floor mean of the two z values, floor square root
// of dx*dx + dy*dy, unit direction in Q1.14 truncated toward zero, and a
// zero_length flag that forces the unit outputs to zero.
// Both channels transfer when valid is high and stall is low.
// Throughput: one request per cycle while req_stall is low, writes and segments mixed freely.
// A segment request passes the table read, the difference and square stages,
// the one-bit-per-stage square root and the restoring dividers before the
// response register.
// A write is visible to a segment request in the very next cycle.
// Reset clears every pipeline valid bit; table contents are undefined until
// written and no clearing pass runs. Reading a never-written slot gives
// undefined fields.
// When rsp_stall is high the pipeline closes up its bubbles and keeps taking
// requests until every stage holds an item, then raises req_stall.
`default_nettype none
module segment_midpoint_length_direction_unit #(
   parameter int POINT_SLOTS = smld_pkg::DEF_POINT_SLOTS,
   parameter int COORD_BITS  = smld_pkg::DEF_COORD_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic        [smld_pkg::INDEX_W-1:0]   req_first_index,
   input  wire logic        [smld_pkg::INDEX_W-1:0]   req_second_index,
   input  wire logic signed [smld_pkg::FIELD_W-1:0]   req_coord_x,
   input  wire logic signed [smld_pkg::FIELD_W-1:0]   req_coord_y,
   input  wire logic signed [smld_pkg::FIELD_W-1:0]   req_coord_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed      [smld_pkg::FIELD_W-1:0]   rsp_mid_depth,
   output logic             [smld_pkg::LENGTH_W-1:0]  rsp_planar_length,
   output logic signed      [smld_pkg::UNIT_W-1:0]    rsp_unit_x,
   output logic signed      [smld_pkg::UNIT_W-1:0]    rsp_unit_y,
   output logic                                       rsp_zero_length
);

   localparam int AW  = $clog2(POINT_SLOTS);
   localparam int CB  = COORD_BITS;
   localparam int EW  = 3 * CB;
   localparam int RW  = CB + 1;
   localparam int FW  = smld_pkg::FIELD_W;
   localparam int QB  = smld_pkg::QUOTIENT_W;
   localparam int DSW = FW + 2;
   localparam int SSW = DSW + 2 * CB;

   logic          accept;
   logic          is_segment;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;
   logic [CB-1:0] cx;
   logic [CB-1:0] cy;
   logic [CB-1:0] cz;
   logic [EW-1:0] rd_a;
   logic [EW-1:0] rd_b;

   logic ready1;
   logic ready2;
   logic ready3;

   assign is_segment = (req_mode == smld_pkg::MODE_SEGMENT);
   assign accept     = req_valid && !req_stall;
   assign addr_a     = AW'(smld_pkg::slot_of(req_first_index, POINT_SLOTS));
   assign addr_b     = AW'(smld_pkg::slot_of(req_second_index, POINT_SLOTS));
   assign cx         = CB'($unsigned(req_coord_x));
   assign cy         = CB'($unsigned(req_coord_y));
   assign cz         = CB'($unsigned(req_coord_z));

   smld_point_mem #(
      .SLOTS (POINT_SLOTS),
      .AW    (AW),
      .EW    (EW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (accept && !is_segment),
      .wr_addr   (addr_a),
      .wr_data   ({cz, cy, cx}),
      .rd_en     (accept && is_segment),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // stage 1: table read data
   logic s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (ready1) begin
         s1_v_ff <= accept && is_segment;
      end
   end

   // stage 2: differences and mid depth
   logic signed [CB:0]   dx_in;
   logic signed [CB:0]   dy_in;
   logic signed [CB:0]   zsum_in;
   logic signed [CB-1:0] mid_in;
   logic [CB-1:0]        magx_in;
   logic [CB-1:0]        magy_in;

   assign dx_in   = $signed({rd_b[CB-1], rd_b[CB-1:0]}) - $signed({rd_a[CB-1], rd_a[CB-1:0]});
   assign dy_in   = $signed({rd_b[2*CB-1], rd_b[2*CB-1:CB]})
                  - $signed({rd_a[2*CB-1], rd_a[2*CB-1:CB]});
   assign zsum_in = $signed({rd_a[3*CB-1], rd_a[3*CB-1:2*CB]})
                  + $signed({rd_b[3*CB-1], rd_b[3*CB-1:2*CB]});
   assign mid_in  = zsum_in[CB:1];
   assign magx_in = dx_in[CB] ? CB'(-dx_in) : CB'(dx_in);
   assign magy_in = dy_in[CB] ? CB'(-dy_in) : CB'(dy_in);

   logic                 s2_v_ff;
   logic signed [FW-1:0] s2_mid_ff;
   logic                 s2_sx_ff;
   logic                 s2_sy_ff;
   logic [CB-1:0]        s2_magx_ff;
   logic [CB-1:0]        s2_magy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (ready2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         s2_mid_ff  <= FW'(mid_in);
         s2_sx_ff   <= dx_in[CB];
         s2_sy_ff   <= dy_in[CB];
         s2_magx_ff <= magx_in;
         s2_magy_ff <= magy_in;
      end
   end

   // stage 3: squares
   logic              s3_v_ff;
   logic [2*CB-1:0]   s3_sqx_ff;
   logic [2*CB-1:0]   s3_sqy_ff;
   logic [SSW-1:0]    s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (ready3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         s3_sqx_ff  <= s2_magx_ff * s2_magx_ff;
         s3_sqy_ff  <= s2_magy_ff * s2_magy_ff;
         s3_side_ff <= {s2_mid_ff, s2_sx_ff, s2_sy_ff, s2_magx_ff, s2_magy_ff};
      end
   end

   // square root
   logic           sq_in_ready;
   logic           sq_out_valid;
   logic           sq_out_ready;
   logic [RW-1:0]  sq_root;
   logic [SSW-1:0] sq_side;

   smld_sqrt #(
      .RW (RW),
      .SW (SSW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (sq_in_ready),
      .in_value  ((2*RW)'(s3_sqx_ff) + (2*RW)'(s3_sqy_ff)),
      .in_side   (s3_side_ff),
      .out_valid (sq_out_valid),
      .out_ready (sq_out_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // dividers
   logic           dv_out_valid;
   logic           out_ready;
   logic [QB-1:0]  quot_x;
   logic [QB-1:0]  quot_y;
   logic [RW-1:0]  dv_len;
   logic [DSW-1:0] dv_side;

   smld_div #(
      .MW (CB),
      .LW (RW),
      .SW (DSW)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sq_out_valid),
      .in_ready   (sq_out_ready),
      .in_mag_x   (sq_side[2*CB-1:CB]),
      .in_mag_y   (sq_side[CB-1:0]),
      .in_len     (sq_root),
      .in_side    (sq_side[SSW-1:2*CB]),
      .out_valid  (dv_out_valid),
      .out_ready  (out_ready),
      .out_quot_x (quot_x),
      .out_quot_y (quot_y),
      .out_len    (dv_len),
      .out_side   (dv_side)
   );

   assign ready3    = !s3_v_ff || sq_in_ready;
   assign ready2    = !s2_v_ff || ready3;
   assign ready1    = !s1_v_ff || ready2;
   assign req_stall = !ready1;

   // response register
   logic                                  rsp_valid_ff;
   logic signed [FW-1:0]                  mid_ff;
   logic [smld_pkg::LENGTH_W-1:0]         len_ff;
   logic signed [smld_pkg::UNIT_W-1:0]    ux_ff;
   logic signed [smld_pkg::UNIT_W-1:0]    uy_ff;
   logic                                  zero_ff;
   logic                                  zero_in;
   logic [smld_pkg::UNIT_W-1:0]           qx_in;
   logic [smld_pkg::UNIT_W-1:0]           qy_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign zero_in   = (dv_len == '0);
   assign qx_in     = smld_pkg::UNIT_W'(quot_x);
   assign qy_in     = smld_pkg::UNIT_W'(quot_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         mid_ff  <= dv_side[DSW-1:2];
         len_ff  <= smld_pkg::LENGTH_W'(dv_len);
         zero_ff <= zero_in;
         if (zero_in) begin
            ux_ff <= '0;
            uy_ff <= '0;
         end else begin
            ux_ff <= dv_side[1] ? -qx_in : qx_in;
            uy_ff <= dv_side[0] ? -qy_in : qy_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mid_depth     = mid_ff;
   assign rsp_planar_length = len_ff;
   assign rsp_unit_x        = ux_ff;
   assign rsp_unit_y        = uy_ff;
   assign rsp_zero_length   = zero_ff;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_zero_unit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_unit_x == '0 && rsp_unit_y == '0)
      else $error("zero length with nonzero direction");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_x <= 16'sd16384 && rsp_unit_x >= -16'sd16384
                 && rsp_unit_y <= 16'sd16384 && rsp_unit_y >= -16'sd16384)
      else $error("direction component out of range");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(len_ff) && $stable(ux_ff))
      else $error("response changed while stalled");

endmodule
`default_nettype wire
